FILE: rtl/rtcal_pkg.sv
// Shared types, constants and calendar helpers for the RTC daily alarm unit.
`default_nettype none

package rtcal_pkg;

  localparam int HOUR_MAX      = 23;
  localparam int MINUTE_MAX    = 59;
  localparam int MIN_PER_HOUR  = 60;
  localparam int YEAR_TOP      = 99;
  localparam int MONTH_TOP     = 12;
  localparam int TOD_W         = 11;  // holds 31*60+63

  localparam int IN_TDATA_W    = 48;
  localparam int IN_TUSER_W    = 1;
  localparam int OUT_TDATA_W   = 24;

  typedef enum logic {
    OP_ARM  = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_CLOCK = 2'd2
  } status_t;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
  } date_t;

  typedef struct packed {
    op_t        operation;
    logic [6:0] set_hour;
    logic [6:0] set_minute;
    date_t      clock_date;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic       clock_valid;
  } item_t;

  typedef struct packed {
    status_t arm_status;
    logic    fired;
    logic    armed_now;
    date_t   goal;
  } result_t;

  // Days in a month; unknown month codes count 30 days.
  function automatic logic [4:0] month_length(input logic [3:0] month,
                                              input logic [6:0] year);
    logic [4:0] len;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd2:    len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
      default: len = 5'd30;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rtcal_in_reg.sv
// Input register stage: capture one request and hold it until the core takes it.
`default_nettype none

module rtcal_in_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rtcal_pkg::item_t in_item,
  input  wire logic           take,
  output logic                held_valid,
  output rtcal_pkg::item_t    held_item
);

  // Free slot, or the held request leaves this cycle.
  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rtcal_next_day.sv
// Calendar step: advance a date by one day when asked, else pass it on.
`default_nettype none

module rtcal_next_day (
  input  wire rtcal_pkg::date_t today,
  input  wire logic             roll,
  output rtcal_pkg::date_t      result
);

  logic [4:0] len;

  assign len = rtcal_pkg::month_length(today.month, today.year);

  always_comb begin
    result = today;
    if (roll) begin
      if (today.day < len) begin
        result.day = today.day + 5'd1;
      end else begin
        result.day = 5'd1;
        if (today.month < 4'(rtcal_pkg::MONTH_TOP)) begin
          result.month = today.month + 4'd1;
        end else begin
          result.month = 4'd1;
          result.year  = (today.year < 7'(rtcal_pkg::YEAR_TOP)) ? today.year + 7'd1 : 7'd0;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rtcal_core.sv
// Alarm state, arm and match decisions, and the result register.
`default_nettype none

module rtcal_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  input  wire rtcal_pkg::item_t item,
  output logic                  take,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output rtcal_pkg::result_t    res
);

  logic             armed, armed_next;
  logic [4:0]       alarm_hour;
  logic [5:0]       alarm_minute;
  rtcal_pkg::date_t target, target_next;
  rtcal_pkg::date_t stepped;

  logic                    is_arm, range_bad, arm_ok, hit, roll;
  logic [rtcal_pkg::TOD_W-1:0] cur_tod, req_tod;
  rtcal_pkg::status_t      status;

  assign take = item_valid && (!res_valid || res_ready);

  assign is_arm    = (item.operation == rtcal_pkg::OP_ARM);
  assign range_bad = (item.set_hour > 7'(rtcal_pkg::HOUR_MAX)) ||
                     (item.set_minute > 7'(rtcal_pkg::MINUTE_MAX));
  assign arm_ok    = is_arm && !range_bad && item.clock_valid;

  assign cur_tod = rtcal_pkg::TOD_W'(item.now_hour) *
                   rtcal_pkg::TOD_W'(rtcal_pkg::MIN_PER_HOUR) +
                   rtcal_pkg::TOD_W'(item.now_minute);
  assign req_tod = rtcal_pkg::TOD_W'(item.set_hour) *
                   rtcal_pkg::TOD_W'(rtcal_pkg::MIN_PER_HOUR) +
                   rtcal_pkg::TOD_W'(item.set_minute);
  assign roll    = (cur_tod >= req_tod);

  rtcal_next_day u_next_day (
    .today  (item.clock_date),
    .roll   (roll),
    .result (stepped)
  );

  assign hit = !is_arm && armed && item.clock_valid &&
               (item.clock_date == target) &&
               (item.now_hour == alarm_hour) &&
               (item.now_minute == alarm_minute);

  always_comb begin
    armed_next  = armed;
    target_next = target;
    if (arm_ok) begin
      armed_next  = 1'b1;
      target_next = stepped;
    end else if (hit) begin
      armed_next = 1'b0;
    end
  end

  always_comb begin
    priority if (!is_arm) begin
      status = rtcal_pkg::ST_OK;
    end else if (range_bad) begin
      status = rtcal_pkg::ST_RANGE;
    end else if (!item.clock_valid) begin
      status = rtcal_pkg::ST_CLOCK;
    end else begin
      status = rtcal_pkg::ST_OK;
    end
  end

  // Alarm state: reset clears it; otherwise only a taken request moves it.
  always_ff @(posedge clk) begin
    if (rst) begin
      armed        <= 1'b0;
      alarm_hour   <= '0;
      alarm_minute <= '0;
      target       <= '0;
    end else if (take) begin
      armed  <= armed_next;
      target <= target_next;
      if (arm_ok) begin
        alarm_hour   <= item.set_hour[4:0];
        alarm_minute <= item.set_minute[5:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.arm_status <= status;
      res.fired      <= hit;
      res.armed_now  <= armed_next;
      res.goal       <= target_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rtc_daily_alarm_unit_top.sv
// Top level of the RTC daily alarm unit: stream ports and field packing.
//
//   channel  direction  handshake                     payload
//   s_axis   in         s_axis_tvalid/s_axis_tready   tdata: set and clock fields, tuser: op
//   m_axis   out        m_axis_tvalid/m_axis_tready   tdata: status, fired, armed, goal date
//
// Each request passes an input register, then compare and calendar-step logic
// into the result register; one request per cycle is sustained while m_axis_tready
// is high. rst (synchronous, active high) disarms the alarm, zeroes the stored
// time and target date, and empties both registers. A stalled m_axis holds its
// result; the input register still fills, and s_axis_tready drops only when both
// are full.
`default_nettype none

module rtc_daily_alarm_unit_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [6:0] set_hour, [13:7] set_minute, [20:14] now_year, [24:21] now_month,
  // [29:25] now_day, [34:30] now_hour, [40:35] now_minute, [41] clock_valid,
  // [47:42] zero
  input  wire logic [rtcal_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] operation
  input  wire logic [rtcal_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [1:0] arm_status, [2] fired, [3] armed_now, [10:4] goal_year,
  // [14:11] goal_month, [19:15] goal_day, [23:20] zero
  output logic [rtcal_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

  rtcal_pkg::item_t   in_item, held_item;
  rtcal_pkg::result_t res;
  logic               held_valid, take;

  // Unpack the request fields, lowest bits first.
  always_comb begin
    in_item.operation        = rtcal_pkg::op_t'(s_axis_tuser[0]);
    in_item.set_hour         = s_axis_tdata[6:0];
    in_item.set_minute       = s_axis_tdata[13:7];
    in_item.clock_date.year  = s_axis_tdata[20:14];
    in_item.clock_date.month = s_axis_tdata[24:21];
    in_item.clock_date.day   = s_axis_tdata[29:25];
    in_item.now_hour         = s_axis_tdata[34:30];
    in_item.now_minute       = s_axis_tdata[40:35];
    in_item.clock_valid      = s_axis_tdata[41];
  end

  // Hold the incoming request until the core takes it.
  rtcal_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // Decide arm/tick, update the alarm, register the result.
  rtcal_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (held_valid),
    .item       (held_item),
    .take       (take),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res        (res)
  );

  // Pack the result fields, lowest bits first, zero-fill the top nibble.
  assign m_axis_tdata = {4'd0, res.goal.day, res.goal.month, res.goal.year,
                         res.armed_now, res.fired, res.arm_status};

endmodule

`default_nettype wire
